### rtl/rcpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcpm_pkg;

    // default cube geometry
    localparam int LAYERS_DEF         = 3;
    localparam int LEDS_PER_LAYER_DEF = 9;

    // fixed result widths
    localparam int DRIVE_W  = 27;
    localparam int SELECT_W = 3;

    localparam logic [7:0] PERIOD_RESET = 8'd255;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        logic       command;
        logic [1:0] layer_addr;
        logic [3:0] led_addr;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]  drive_bits;
        logic [SELECT_W-1:0] layer_select;
        logic [7:0]          pwm_position;
    } out_t;

endpackage

`default_nettype wire

### rtl/rcpm_colour_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rcpm_colour_store #(
    parameter int LAYERS         = rcpm_pkg::LAYERS_DEF,
    parameter int LEDS_PER_LAYER = rcpm_pkg::LEDS_PER_LAYER_DEF,
    parameter int LW             = $clog2(LAYERS)
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     wr_en,
    input  wire logic [1:0]                               wr_layer,
    input  wire logic [3:0]                               wr_led,
    input  wire rcpm_pkg::colour_t                        wr_colour,
    input  wire logic [LW-1:0]                            rd_layer,
    output rcpm_pkg::colour_t [LEDS_PER_LAYER-1:0]        rd_row
);
    import rcpm_pkg::*;

    colour_t [LEDS_PER_LAYER-1:0] store_reg [LAYERS];

    // one flop entry per led, cleared at reset; out-of-range writes match nothing
    for (genvar l = 0; l < LAYERS; l++) begin : g_layer
        for (genvar i = 0; i < LEDS_PER_LAYER; i++) begin : g_led
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    store_reg[l][i] <= '0;
                end else if (wr_en && (32'(wr_layer) == l) && (32'(wr_led) == i)) begin
                    store_reg[l][i] <= wr_colour;
                end
            end
        end
    end

    assign rd_row = store_reg[rd_layer];

endmodule

`default_nettype wire

### rtl/rcpm_pwm_counter.sv
`timescale 1ns / 1ps
`default_nettype none

module rcpm_pwm_counter #(
    parameter int LAYERS = rcpm_pkg::LAYERS_DEF,
    parameter int LW     = $clog2(LAYERS)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          tick,
    output logic [7:0]         pos_next,
    output logic [LW-1:0]      layer_next
);
    import rcpm_pkg::*;

    logic [7:0]    period_reg;
    logic [7:0]    pos_reg;
    logic [LW-1:0] layer_reg;
    logic [8:0]    pos_inc;
    logic [LW:0]   layer_inc;
    logic          wrap;

    // position step and layer advance on wrap
    always_comb begin
        pos_inc   = {1'b0, pos_reg} + 9'd1;
        wrap      = pos_inc >= {1'b0, period_reg};
        layer_inc = {1'b0, layer_reg} + (LW+1)'(1);
        pos_next  = wrap ? 8'd0 : pos_inc[7:0];
        if (!wrap) begin
            layer_next = layer_reg;
        end else if (layer_inc >= (LW+1)'(LAYERS)) begin
            layer_next = '0;
        end else begin
            layer_next = layer_inc[LW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            pos_reg    <= '0;
            layer_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (tick) begin
                pos_reg   <= pos_next;
                layer_reg <= layer_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rcpm_compare.sv
`timescale 1ns / 1ps
`default_nettype none

module rcpm_compare #(
    parameter int LEDS_PER_LAYER = rcpm_pkg::LEDS_PER_LAYER_DEF
) (
    input  wire logic [7:0]                              pos,
    input  wire rcpm_pkg::colour_t [LEDS_PER_LAYER-1:0]  row,
    output logic [rcpm_pkg::DRIVE_W-1:0]                 drive_bits
);
    import rcpm_pkg::*;

    localparam int BW = 3 * LEDS_PER_LAYER;

    logic [BW-1:0] raw;

    // red bit 0, green bit 1, blue bit 2 per led
    for (genvar i = 0; i < LEDS_PER_LAYER; i++) begin : g_led
        assign raw[3*i]   = pos < row[i].red;
        assign raw[3*i+1] = pos < row[i].green;
        assign raw[3*i+2] = pos < row[i].blue;
    end

    assign drive_bits = DRIVE_W'(raw);

endmodule

`default_nettype wire

### rtl/rgb_cube_pwm_multiplexer.sv
// a tick transaction is held in the input register, then compared into the result register;
// writes give no result
// throughput: one transaction per cycle unless a tick waits on a stalled result channel, set by
// the single compare pass between the input register and the result register
// reset: synchronous active-low; colours cleared, position and layer zero,
// period 255
`timescale 1ns / 1ps
`default_nettype none

module rgb_cube_pwm_multiplexer #(
    parameter int LAYERS         = rcpm_pkg::LAYERS_DEF,
    parameter int LEDS_PER_LAYER = rcpm_pkg::LEDS_PER_LAYER_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // configuration: pwm period
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    // command channel
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rcpm_pkg::in_t s_data,
    // result channel
    output logic               m_valid,
    input  wire logic          m_ready,
    output rcpm_pkg::out_t     m_data
);
    import rcpm_pkg::*;

    localparam int LW = $clog2(LAYERS);

    // input register
    in_t  in_reg;
    logic in_valid_reg;

    // result register
    out_t out_reg;
    logic out_valid_reg;

    logic                          advance;
    logic                          is_tick;
    logic                          tick;
    logic                          wr_en;
    logic [7:0]                    pos_next;
    logic [LW-1:0]                 layer_next;
    logic [LAYERS-1:0]             layer_onehot;
    colour_t [LEDS_PER_LAYER-1:0]  row;
    logic [DRIVE_W-1:0]            drive_bits;
    colour_t                       wr_colour;

    // a write never needs the result register, a tick needs it free or draining
    assign is_tick = in_reg.command == CMD_TICK;
    assign advance = in_valid_reg && (!is_tick || !out_valid_reg || m_ready);
    assign tick    = advance && is_tick;
    assign wr_en   = advance && (in_reg.command == CMD_WRITE);

    // input register refills in the same cycle it drains
    assign s_ready = !in_valid_reg || advance;

    assign wr_colour = '{red: in_reg.red_in, green: in_reg.green_in, blue: in_reg.blue_in};

    rcpm_colour_store #(
        .LAYERS         (LAYERS),
        .LEDS_PER_LAYER (LEDS_PER_LAYER),
        .LW             (LW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_layer  (in_reg.layer_addr),
        .wr_led    (in_reg.led_addr),
        .wr_colour (wr_colour),
        .rd_layer  (layer_next),
        .rd_row    (row)
    );

    // position and layer counters, period register
    rcpm_pwm_counter #(
        .LAYERS (LAYERS),
        .LW     (LW)
    ) u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (tick),
        .pos_next    (pos_next),
        .layer_next  (layer_next)
    );

    // compare the stepped position against the row of the new layer
    rcpm_compare #(
        .LEDS_PER_LAYER (LEDS_PER_LAYER)
    ) u_compare (
        .pos        (pos_next),
        .row        (row),
        .drive_bits (drive_bits)
    );

    assign layer_onehot = LAYERS'(1) << layer_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (tick) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (tick) begin
            out_reg.drive_bits   <= drive_bits;
            out_reg.layer_select <= SELECT_W'(layer_onehot);
            out_reg.pwm_position <= pos_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### verif/tb_rgb_cube_pwm_multiplexer.sv
`timescale 1ns / 1ps

module tb_rgb_cube_pwm_multiplexer;

    import rcpm_pkg::*;

    // cube geometry follows the block defaults
    localparam int LAYERS = LAYERS_DEF;
    localparam int LEDS   = LEDS_PER_LAYER_DEF;
    localparam int CELLS  = LAYERS * LEDS;

    localparam int CLK_HALF     = 6;       // 12 ns period
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 4;       // two register stages plus margin
    localparam int DRAIN_LIMIT  = 50000;   // cycles to wait for a phase to empty
    localparam int REPORT_CAP   = 100;     // keep the log short on a broken block
    localparam longint TIMEOUT_NS = 64'd2_400_000;

    // traffic shapes for the two channels
    typedef enum {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_mode_e;

    // all block inputs start known
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_t        s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_t       m_data;

    // commands waiting for the driver, frames waiting for the block
    in_t  pending_cmds[$];
    out_t expected_frames[$];

    // shadow of the cube: colours, pwm position, active layer, period
    colour_t     cube_colours [CELLS];
    logic [7:0]  cur_pos;
    int unsigned cur_layer;
    logic [7:0]  cur_period;

    // idle percentages for the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // bookkeeping
    int mismatch_count = 0;
    int tick_count     = 0;
    int write_count    = 0;
    int frames_checked = 0;
    int period_count   = 0;

    rgb_cube_pwm_multiplexer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // one line per mismatch, printing capped but counting never stops
    task automatic flag_mismatch(string what, longint got, longint want);
        if (mismatch_count < REPORT_CAP) begin
            $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // apply one accepted transaction to the shadow cube; a tick queues its frame
    function automatic void step_cube(in_t cmd);
        int unsigned next_pos;
        int unsigned at;
        out_t        frame;
        if (cmd.command == CMD_WRITE) begin
            write_count++;
            // addresses past the cube are dropped
            if (cmd.layer_addr < LAYERS && cmd.led_addr < LEDS) begin
                at = cmd.layer_addr * LEDS + cmd.led_addr;
                cube_colours[at].red   = cmd.red_in;
                cube_colours[at].green = cmd.green_in;
                cube_colours[at].blue  = cmd.blue_in;
            end
            return;
        end
        tick_count++;
        // step the position; a wrap (also any period below two, or a period
        // lowered under the position) moves to the next layer
        next_pos = int'(cur_pos) + 1;
        if (next_pos >= cur_period) begin
            next_pos  = 0;
            cur_layer = (cur_layer + 1 >= LAYERS) ? 0 : cur_layer + 1;
        end
        cur_pos = next_pos[7:0];
        // per led: red, green, blue lit while position is below intensity
        frame = '0;
        for (int i = 0; i < LEDS; i++) begin
            at = cur_layer * LEDS + i;
            frame.drive_bits[3*i]     = cur_pos < cube_colours[at].red;
            frame.drive_bits[3*i + 1] = cur_pos < cube_colours[at].green;
            frame.drive_bits[3*i + 2] = cur_pos < cube_colours[at].blue;
        end
        frame.layer_select = SELECT_W'(1) << cur_layer;
        frame.pwm_position = cur_pos;
        expected_frames.push_back(frame);
    endfunction

    function automatic in_t make_tick();
        in_t cmd;
        // payload bits other than the command are don't-care on a tick
        cmd = in_t'($urandom);
        cmd.command = CMD_TICK;
        return cmd;
    endfunction

    function automatic in_t make_write(logic [1:0] layer, logic [3:0] led,
                                       logic [7:0] red, logic [7:0] green,
                                       logic [7:0] blue);
        in_t cmd;
        cmd.command    = CMD_WRITE;
        cmd.layer_addr = layer;
        cmd.led_addr   = led;
        cmd.red_in     = red;
        cmd.green_in   = green;
        cmd.blue_in    = blue;
        return cmd;
    endfunction

    // intensity near the pwm range half the time so compares go both ways
    function automatic logic [7:0] pick_level(logic [7:0] period);
        int span;
        span = (period < 8'd255) ? int'(period) + 1 : 255;
        if ($urandom_range(1) == 0) begin
            return 8'($urandom_range(span));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic in_t random_command(logic [7:0] period, int tick_pct);
        logic [1:0] layer;
        logic [3:0] led;
        if ($urandom_range(99) < tick_pct) begin
            return make_tick();
        end
        // mostly real cube cells, some writes off the edge
        layer = ($urandom_range(9) == 0) ? 2'($urandom_range(3))
                                         : 2'($urandom_range(LAYERS - 1));
        led   = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                         : 4'($urandom_range(LEDS - 1));
        return make_write(layer, led, pick_level(period), pick_level(period),
                          pick_level(period));
    endfunction

    // wait until every transaction is in and every frame is out, then let
    // the pipeline settle so a trailing write has landed
    task automatic wait_drained();
        int waited;
        waited = 0;
        do begin
            @(negedge aclk);
            waited++;
        end while ((pending_cmds.size() != 0 || s_valid || expected_frames.size() != 0)
                   && waited < DRAIN_LIMIT);
        if (expected_frames.size() != 0) begin
            flag_mismatch("frames never delivered", expected_frames.size(), 0);
            expected_frames.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // idle the block, program the period, pick the traffic shape, queue work
    task automatic run_phase(logic [7:0] period, flow_mode_e mode, int count,
                             int tick_pct);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= period;
        cur_period   = period;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        period_count++;
        @(negedge aclk);
        case (mode)
            FLOW_FREE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            FLOW_SENDER_IDLE: begin
                send_idle_pct  = 84;
                recv_stall_pct = 0;
            end
            FLOW_RECEIVER_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 84;
            end
            default: begin
                send_idle_pct  = 34;
                recv_stall_pct = 34;
            end
        endcase
        repeat (count) pending_cmds.push_back(random_command(period, tick_pct));
    endtask

    // driver: predict on acceptance, then present the next transaction or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                step_cube(s_data);
            end
            // valid only drops or moves on once the current transaction is taken
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each delivered frame against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    flag_mismatch("unexpected frame", m_data, 0);
                end else begin
                    if (m_data.drive_bits !== expected_frames[0].drive_bits) begin
                        flag_mismatch("drive_bits", m_data.drive_bits,
                                      expected_frames[0].drive_bits);
                    end
                    if (m_data.layer_select !== expected_frames[0].layer_select) begin
                        flag_mismatch("layer_select", m_data.layer_select,
                                      expected_frames[0].layer_select);
                    end
                    if (m_data.pwm_position !== expected_frames[0].pwm_position) begin
                        flag_mismatch("pwm_position", m_data.pwm_position,
                                      expected_frames[0].pwm_position);
                    end
                    void'(expected_frames.pop_front());
                    frames_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // stimulus
    initial begin
        // shadow starts in the reset state: all leds dark, position and layer zero
        foreach (cube_colours[i]) cube_colours[i] = '0;
        cur_pos    = 8'd0;
        cur_layer  = 0;
        cur_period = PERIOD_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full-scale period, extremes of colour and address
        run_phase(8'd255, FLOW_FREE, 0, 0);
        pending_cmds.push_back(make_tick());              // cleared store, all dark
        pending_cmds.push_back(make_write(2'd0, 4'd0, 8'hff, 8'hff, 8'hff));
        pending_cmds.push_back(make_write(2'd0, 4'd8, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(make_write(2'd0, 4'd1, 8'h01, 8'h80, 8'hfe));
        pending_cmds.push_back(make_write(2'd0, 4'd4, 8'h03, 8'h02, 8'h05));
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_write(2'd1, 4'd4, 8'h80, 8'h01, 8'hff));
        pending_cmds.push_back(make_write(2'd2, 4'd8, 8'hff, 8'h00, 8'h7f));
        pending_cmds.push_back(make_write(2'd2, 4'd0, 8'h02, 8'h03, 8'h04));
        // writes off the edge of the cube must leave the store alone
        pending_cmds.push_back(make_write(2'd3, 4'd0, 8'haa, 8'haa, 8'haa));
        pending_cmds.push_back(make_write(2'd0, 4'd9, 8'h55, 8'h55, 8'h55));
        pending_cmds.push_back(make_write(2'd1, 4'd15, 8'hff, 8'hff, 8'hff));
        pending_cmds.push_back(make_write(2'd3, 4'd15, 8'hff, 8'hff, 8'hff));
        repeat (6) pending_cmds.push_back(make_tick());   // position walks past 3..5

        // smallest legal period, lowered under the current position
        run_phase(8'd2, FLOW_SENDER_IDLE, 40, 60);
        // full period, tick-heavy so the position reaches its top and wraps
        run_phase(8'd255, FLOW_FREE, 260, 98);
        run_phase(8'd5, FLOW_RECEIVER_STALL, 40, 60);
        // periods below two wrap on every tick
        run_phase(8'd1, FLOW_BOTH, 30, 70);
        run_phase(8'd0, FLOW_SENDER_IDLE, 30, 70);
        run_phase(8'($urandom_range(16, 3)), FLOW_BOTH, 40, 60);
        run_phase(8'($urandom_range(40, 2)), FLOW_RECEIVER_STALL, 40, 60);
        wait_drained();

        $display("run covered %0d ticks and %0d colour writes over %0d period settings",
                 tick_count, write_count, period_count);
        $display("%0d frames checked, %0d mismatches", frames_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d frames outstanding", expected_frames.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
